>>> hdl/i2cbm_pkg.sv
// Shared types and constants for the I2C bit-level master.
// Used by the controller, the datapath and the top level.
package i2cbm_pkg;

  localparam int unsigned PhaseW = 16;
  localparam logic [PhaseW-1:0] PhaseCyclesReset = 16'd1000;

  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_STOP     = 3'd1,
    OP_WRITE    = 3'd2,
    OP_READ     = 3'd3,
    OP_SEND_ACK = 3'd4,
    OP_RECV_ACK = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_WAIT,
    ST_HOLD
  } state_t;

  typedef enum logic [2:0] {
    PK_SDA_HI,
    PK_SDA_LO,
    PK_SDA_BIT,
    PK_SDA_ACK,
    PK_SCL_HI,
    PK_SCL_LO
  } phase_kind_t;

  typedef struct packed {
    logic        load;
    logic        emit;
    phase_kind_t kind;
    logic        sample;
    logic        show_rd;
    logic        show_ack;
    logic        last;
    logic        load_timer;
    logic        hold_run;
  } dp_cmd_t;

  typedef struct packed {
    logic timer_done;
  } dp_status_t;

endpackage

>>> hdl/i2cbm_ifs.sv
// Valid/ready channel interfaces for the I2C bit-level master.
// Command beats in, pin phase beats out; no package dependency.
interface i2cbm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] write_byte;
  logic       ack_drive;
  logic [7:0] line_bits;

  modport source (output valid, opcode, write_byte, ack_drive, line_bits, input ready);
  modport sink (input valid, opcode, write_byte, ack_drive, line_bits, output ready);
endinterface

interface i2cbm_phase_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic [7:0] read_data;
  logic       ack_seen;
  logic       last_phase;

  modport source (output valid, scl_level, sda_level, read_data, ack_seen, last_phase,
                  input ready);
  modport sink (input valid, scl_level, sda_level, read_data, ack_seen, last_phase,
                output ready);
endinterface

>>> hdl/i2c_bit_level_master_top.sv
// Channel     Dir  Payload                                         Handshake
// cmd         in   opcode, write_byte, ack_drive, line_bits        valid/ready
// phase       out  scl_level, sda_level, read_data, ack_seen, last valid/ready
// cfg         in   cfg_wdata (phase_cycles)                        cfg_we
//
// One command beat gives 4 (start), 3 (stop, acks), 24 (write) or 17 (read) phase beats.
// Each phase is formed in ST_EMIT, waits in ST_WAIT for its beat to be taken, then holds
// in ST_HOLD until the hold counter, loaded from phase_cycles, runs out.
// Unknown opcodes are taken and give no beat. cmd.ready is high only
// between commands. Reset (rst, synchronous) releases both lines, phase_cycles = 1000.
// Top level of the I2C bit-level master; depends on i2cbm_pkg, i2cbm_ifs,
// i2cbm_ctrl and i2cbm_dp.
module i2c_bit_level_master_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [i2cbm_pkg::PhaseW-1:0]  cfg_wdata,
  i2cbm_cmd_if.sink                     cmd,
  i2cbm_phase_if.source                 phase
);

  i2cbm_pkg::dp_cmd_t    dp_cmd;
  i2cbm_pkg::dp_status_t dp_status;

  i2cbm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .opcode    (cmd.opcode),
    .out_valid (phase.valid),
    .out_ready (phase.ready),
    .cmd       (dp_cmd),
    .status    (dp_status)
  );

  i2cbm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .opcode     (cmd.opcode),
    .write_byte (cmd.write_byte),
    .ack_drive  (cmd.ack_drive),
    .line_bits  (cmd.line_bits),
    .cmd        (dp_cmd),
    .status     (dp_status),
    .scl_level  (phase.scl_level),
    .sda_level  (phase.sda_level),
    .read_data  (phase.read_data),
    .ack_seen   (phase.ack_seen),
    .last_phase (phase.last_phase)
  );

`ifndef NO_ASSERTIONS
  a_no_cmd_while_phase: assert property (@(posedge clk) disable iff (rst)
    phase.valid |-> !cmd.ready)
    else $error("command taken while a phase beat is pending");

  a_hold_after_beat: assert property (@(posedge clk) disable iff (rst)
    (phase.valid && phase.ready) |=> !phase.valid)
    else $error("phase beat not followed by a hold");

  a_read_data_last: assert property (@(posedge clk) disable iff (rst)
    (phase.valid && (phase.read_data != 8'd0)) |-> phase.last_phase)
    else $error("read data shown before the last phase");

  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    (phase.valid && phase.ack_seen) |-> phase.last_phase)
    else $error("ack shown before the last phase");
`endif

endmodule

>>> hdl/i2cbm_ctrl.sv
// Controller for the I2C bit-level master: command FSM and phase sequencing.
// Depends on i2cbm_pkg; drives the datapath through dp_cmd_t.
module i2cbm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             opcode,
  output logic                   out_valid,
  input  logic                   out_ready,
  output i2cbm_pkg::dp_cmd_t     cmd,
  input  i2cbm_pkg::dp_status_t  status
);

  i2cbm_pkg::state_t state, state_next;
  i2cbm_pkg::op_t    op;
  logic [1:0]        sub;
  logic [2:0]        bitn;
  logic              op_known;
  logic              last;
  i2cbm_pkg::phase_kind_t kind;
  logic              sample;
  logic              show_rd;
  logic              show_ack;

  assign op_known = (opcode == i2cbm_pkg::OP_START) || (opcode == i2cbm_pkg::OP_STOP) ||
                    (opcode == i2cbm_pkg::OP_WRITE) || (opcode == i2cbm_pkg::OP_READ) ||
                    (opcode == i2cbm_pkg::OP_SEND_ACK) || (opcode == i2cbm_pkg::OP_RECV_ACK);

  // phase decode from opcode and step position
  always_comb begin
    kind     = i2cbm_pkg::PK_SCL_LO;
    sample   = 1'b0;
    show_rd  = 1'b0;
    show_ack = 1'b0;
    last     = 1'b0;
    case (op)
      i2cbm_pkg::OP_START: begin
        case (sub)
          2'd0: kind = i2cbm_pkg::PK_SDA_HI;
          2'd1: kind = i2cbm_pkg::PK_SCL_HI;
          2'd2: kind = i2cbm_pkg::PK_SDA_LO;
          default: begin
            kind = i2cbm_pkg::PK_SCL_LO;
            last = 1'b1;
          end
        endcase
      end
      i2cbm_pkg::OP_STOP: begin
        case (sub)
          2'd0: kind = i2cbm_pkg::PK_SDA_LO;
          2'd1: kind = i2cbm_pkg::PK_SCL_HI;
          default: begin
            kind = i2cbm_pkg::PK_SDA_HI;
            last = 1'b1;
          end
        endcase
      end
      i2cbm_pkg::OP_WRITE: begin
        case (sub)
          2'd0: kind = i2cbm_pkg::PK_SDA_BIT;
          2'd1: kind = i2cbm_pkg::PK_SCL_HI;
          default: begin
            kind = i2cbm_pkg::PK_SCL_LO;
            last = (bitn == 3'd7);
          end
        endcase
      end
      i2cbm_pkg::OP_READ: begin
        case (sub)
          2'd0: kind = i2cbm_pkg::PK_SDA_HI;
          2'd1: begin
            kind   = i2cbm_pkg::PK_SCL_HI;
            sample = 1'b1;
          end
          default: begin
            kind    = i2cbm_pkg::PK_SCL_LO;
            last    = (bitn == 3'd7);
            show_rd = (bitn == 3'd7);
          end
        endcase
      end
      i2cbm_pkg::OP_SEND_ACK: begin
        case (sub)
          2'd0: kind = i2cbm_pkg::PK_SDA_ACK;
          2'd1: kind = i2cbm_pkg::PK_SCL_HI;
          default: begin
            kind = i2cbm_pkg::PK_SCL_LO;
            last = 1'b1;
          end
        endcase
      end
      i2cbm_pkg::OP_RECV_ACK: begin
        case (sub)
          2'd0: kind = i2cbm_pkg::PK_SDA_HI;
          2'd1: kind = i2cbm_pkg::PK_SCL_HI;
          default: begin
            kind     = i2cbm_pkg::PK_SCL_LO;
            last     = 1'b1;
            show_ack = 1'b1;
          end
        endcase
      end
      default: begin
        kind = i2cbm_pkg::PK_SCL_LO;
        last = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      i2cbm_pkg::ST_IDLE: begin
        if (in_valid && op_known) state_next = i2cbm_pkg::ST_EMIT;
      end
      i2cbm_pkg::ST_EMIT: state_next = i2cbm_pkg::ST_WAIT;
      i2cbm_pkg::ST_WAIT: begin
        if (out_ready) state_next = i2cbm_pkg::ST_HOLD;
      end
      i2cbm_pkg::ST_HOLD: begin
        if (status.timer_done) state_next = last ? i2cbm_pkg::ST_IDLE : i2cbm_pkg::ST_EMIT;
      end
      default: state_next = i2cbm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state == i2cbm_pkg::ST_IDLE);
    out_valid      = (state == i2cbm_pkg::ST_WAIT);
    cmd.load       = (state == i2cbm_pkg::ST_IDLE) && in_valid;
    cmd.emit       = (state == i2cbm_pkg::ST_EMIT);
    cmd.kind       = kind;
    cmd.sample     = sample;
    cmd.show_rd    = show_rd;
    cmd.show_ack   = show_ack;
    cmd.last       = last;
    cmd.load_timer = (state == i2cbm_pkg::ST_WAIT) && out_ready;
    cmd.hold_run   = (state == i2cbm_pkg::ST_HOLD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2cbm_pkg::ST_IDLE;
      op    <= i2cbm_pkg::OP_START;
      sub   <= 2'd0;
      bitn  <= 3'd0;
    end else begin
      state <= state_next;
      if ((state == i2cbm_pkg::ST_IDLE) && in_valid && op_known) begin
        op   <= i2cbm_pkg::op_t'(opcode);
        sub  <= 2'd0;
        bitn <= 3'd0;
      end else if ((state == i2cbm_pkg::ST_HOLD) && status.timer_done && !last) begin
        // advance to the next phase of the run
        if ((op == i2cbm_pkg::OP_WRITE) && (sub == 2'd2)) begin
          sub  <= 2'd0;
          bitn <= bitn + 3'd1;
        end else if ((op == i2cbm_pkg::OP_READ) && (sub == 2'd2)) begin
          sub  <= 2'd1;
          bitn <= bitn + 3'd1;
        end else begin
          sub <= sub + 2'd1;
        end
      end
    end
  end

endmodule

>>> hdl/i2cbm_dp.sv
// Datapath for the I2C bit-level master: line levels, shift registers,
// phase hold timer and the result payload. Depends on i2cbm_pkg.
module i2cbm_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [i2cbm_pkg::PhaseW-1:0]        cfg_wdata,
  input  logic [2:0]                          opcode,
  input  logic [7:0]                          write_byte,
  input  logic                                ack_drive,
  input  logic [7:0]                          line_bits,
  input  i2cbm_pkg::dp_cmd_t                  cmd,
  output i2cbm_pkg::dp_status_t               status,
  output logic                                scl_level,
  output logic                                sda_level,
  output logic [7:0]                          read_data,
  output logic                                ack_seen,
  output logic                                last_phase
);

  logic [i2cbm_pkg::PhaseW-1:0] phase_cycles;
  logic [i2cbm_pkg::PhaseW-1:0] timer;
  logic                         scl;
  logic                         sda;
  logic [7:0]                   sreg;
  logic [7:0]                   lbits;
  logic                         ackl;

  assign status.timer_done = (timer <= i2cbm_pkg::PhaseW'(1));
  assign scl_level = scl;
  assign sda_level = sda;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_cycles <= i2cbm_pkg::PhaseCyclesReset;
      scl          <= 1'b1;
      sda          <= 1'b1;
    end else begin
      if (cfg_we) phase_cycles <= cfg_wdata;
      if (cmd.emit) begin
        case (cmd.kind)
          i2cbm_pkg::PK_SDA_HI:  sda <= 1'b1;
          i2cbm_pkg::PK_SDA_LO:  sda <= 1'b0;
          i2cbm_pkg::PK_SDA_BIT: sda <= sreg[7];
          i2cbm_pkg::PK_SDA_ACK: sda <= ackl;
          i2cbm_pkg::PK_SCL_HI:  scl <= 1'b1;
          i2cbm_pkg::PK_SCL_LO:  scl <= 1'b0;
          default:               scl <= scl;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sreg  <= (opcode == i2cbm_pkg::OP_WRITE) ? write_byte : 8'd0;
      lbits <= line_bits;
      ackl  <= ack_drive;
    end else if (cmd.emit) begin
      if (cmd.kind == i2cbm_pkg::PK_SDA_BIT) sreg <= {sreg[6:0], 1'b0};
      if (cmd.sample) begin
        sreg  <= {sreg[6:0], lbits[7]};
        lbits <= {lbits[6:0], 1'b0};
      end
    end
    if (cmd.emit) begin
      read_data  <= cmd.show_rd ? sreg : 8'd0;
      ack_seen   <= cmd.show_ack ? lbits[7] : 1'b0;
      last_phase <= cmd.last;
    end
    if (cmd.load_timer) begin
      timer <= phase_cycles;
    end else if (cmd.hold_run && !status.timer_done) begin
      timer <= timer - i2cbm_pkg::PhaseW'(1);
    end
  end

endmodule
